[rtl/qrr_pkg.sv]
`default_nettype none
package qrr_pkg;

   localparam int COEF_W    = 16;
   localparam int KIND_W    = 2;
   localparam int DISC_W    = 24;
   localparam int ROOT_W    = 32;

   // product, discriminant and scaled magnitude widths
   localparam int PROD_W    = 2 * COEF_W;
   localparam int DISC_RAW_W = PROD_W + 2;
   localparam int SCALE_W   = 40;
   localparam int ROUND_SH  = 16;

   // integer square root of k * 65536
   localparam int SQ_IN_W   = 40;
   localparam int SQ_STEPS  = SQ_IN_W / 2;
   localparam int SQ_ROOT_W = SQ_STEPS;
   localparam int SQ_REM_W  = SQ_ROOT_W + 4;

   // divide by ten as multiply by reciprocal, exact below 2^22
   localparam int DIV10_MUL_W = 20;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 20'd838861;
   localparam int DIV10_SH  = 23;
   localparam int S_W       = 17;

   // root numerator and divisor
   localparam int SUM_W     = S_W + 1;
   localparam int NUM_W     = S_W + 8;
   localparam int DEN_W     = COEF_W + 1;
   localparam int DV_STEPS  = NUM_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_TWO   = 2'd0,
      KIND_ONE   = 2'd1,
      KIND_NONE  = 2'd2,
      KIND_AZERO = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [DISC_W-1:0]   k;
      logic signed [COEF_W-1:0]   a;
      logic signed [COEF_W-1:0]   b;
   } sq_side_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [DISC_W-1:0]   k;
      logic                       neg_p;
      logic                       neg_m;
   } dv_side_type;

endpackage
`default_nettype wire

[rtl/qrr_isqrt.sv]
`default_nettype none
module qrr_isqrt (
   input  wire logic                          clock,
   input  wire logic                          adv,
   input  wire logic [qrr_pkg::SQ_IN_W-1:0]   n_in,
   output logic      [qrr_pkg::SQ_ROOT_W-1:0] root_out
);
   import qrr_pkg::*;

   logic [SQ_IN_W-1:0]   n_ff    [SQ_STEPS];
   logic [SQ_REM_W-1:0]  rem_ff  [SQ_STEPS];
   logic [SQ_ROOT_W-1:0] root_ff [SQ_STEPS];

   // one result bit per stage, most significant pair first
   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
      localparam int P = SQ_STEPS - 1 - i;
      logic [SQ_IN_W-1:0]   n_cur;
      logic [SQ_REM_W-1:0]  rem_cur;
      logic [SQ_ROOT_W-1:0] root_cur;
      logic [SQ_REM_W-1:0]  rem_sh;
      logic [SQ_REM_W-1:0]  trial;
      logic                 take;

      if (i == 0) begin : g_first
         assign n_cur    = n_in;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign n_cur    = n_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign root_cur = root_ff[i-1];
      end

      assign rem_sh = {rem_cur[SQ_REM_W-3:0], n_cur[2*P+1 -: 2]};
      assign trial  = {2'b00, root_cur, 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[i]    <= n_cur;
            rem_ff[i]  <= take ? rem_sh - trial : rem_sh;
            root_ff[i] <= {root_cur[SQ_ROOT_W-2:0], take};
         end
      end
   end

   assign root_out = root_ff[SQ_STEPS-1];

endmodule
`default_nettype wire

[rtl/qrr_div.sv]
`default_nettype none
module qrr_div (
   input  wire logic                      clock,
   input  wire logic                      adv,
   input  wire logic [qrr_pkg::NUM_W-1:0] num_in,
   input  wire logic [qrr_pkg::DEN_W-1:0] den_in,
   output logic      [qrr_pkg::NUM_W-1:0] quo_out
);
   import qrr_pkg::*;

   logic [NUM_W-1:0] num_ff [DV_STEPS];
   logic [DEN_W-1:0] den_ff [DV_STEPS];
   logic [DEN_W:0]   rem_ff [DV_STEPS];
   logic [NUM_W-1:0] quo_ff [DV_STEPS];

   // restoring division, one quotient bit per stage
   for (genvar i = 0; i < DV_STEPS; i++) begin : g_step
      localparam int P = DV_STEPS - 1 - i;
      logic [NUM_W-1:0] num_cur;
      logic [DEN_W-1:0] den_cur;
      logic [DEN_W:0]   rem_cur;
      logic [NUM_W-1:0] quo_cur;
      logic [DEN_W:0]   rem_sh;
      logic             take;

      if (i == 0) begin : g_first
         assign num_cur = num_in;
         assign den_cur = den_in;
         assign rem_cur = '0;
         assign quo_cur = '0;
      end else begin : g_next
         assign num_cur = num_ff[i-1];
         assign den_cur = den_ff[i-1];
         assign rem_cur = rem_ff[i-1];
         assign quo_cur = quo_ff[i-1];
      end

      assign rem_sh = {rem_cur[DEN_W-1:0], num_cur[P]};
      assign take   = rem_sh >= {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[i] <= num_cur;
            den_ff[i] <= den_cur;
            rem_ff[i] <= take ? rem_sh - {1'b0, den_cur} : rem_sh;
            quo_ff[i] <= {quo_cur[NUM_W-2:0], take};
         end
      end
   end

   assign quo_out = quo_ff[DV_STEPS-1];

endmodule
`default_nettype wire

[rtl/quadratic_real_root_solver_core.sv]
`default_nettype none
// channel  | dir | handshake             | beat
// ---------+-----+-----------------------+-----------------------------------------
// req      | in  | req_valid / req_ready | coef_a, coef_b, coef_c (Q8.8)
// rsp      | out | rsp_valid / rsp_ready | root_kind, disc_hundredths, root_plus/minus
//
// One beat per cycle in and out. Stages: 3 front stages, 20-stage square root,
// 2 stages for the divide by ten and numerators, 25-stage divider, output
// register. Synchronous reset clears the valid line only.
// A stalled rsp beat freezes the whole pipeline; req_ready drops with it.
module quadratic_real_root_solver_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [qrr_pkg::COEF_W-1:0]   req_coef_a,
   input  wire logic signed [qrr_pkg::COEF_W-1:0]   req_coef_b,
   input  wire logic signed [qrr_pkg::COEF_W-1:0]   req_coef_c,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic             [qrr_pkg::KIND_W-1:0]   rsp_root_kind,
   output logic signed      [qrr_pkg::DISC_W-1:0]   rsp_disc_hundredths,
   output logic signed      [qrr_pkg::ROOT_W-1:0]   rsp_root_plus,
   output logic signed      [qrr_pkg::ROOT_W-1:0]   rsp_root_minus
);
   import qrr_pkg::*;

   localparam int VLD_N = 6 + SQ_STEPS + DV_STEPS;

   logic                   adv;
   logic [VLD_N-1:0]       vld_ff;
   logic [VLD_N-1:0]       vld_in;

   // front stages
   logic signed [PROD_W-1:0]     bb1_ff, ac1_ff;
   logic signed [COEF_W-1:0]     a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [DISC_RAW_W-1:0] d2_ff, d2_in;
   logic                         neg3;
   logic [DISC_RAW_W-1:0]        mag3;
   logic [SCALE_W-1:0]           mag3w, scaled3;
   logic [DISC_W-1:0]            kmag3;
   kind_type                     kind3;
   sq_side_type                  side3_ff, side3_in;
   logic [SQ_IN_W-1:0]           sqn3_ff, sqn3_in;

   // square root and side delay
   logic [SQ_ROOT_W-1:0]         root_w;
   sq_side_type                  sqside_ff [SQ_STEPS];

   // reciprocal multiply
   logic [SQ_ROOT_W+DIV10_MUL_W-1:0] prod4_ff;
   sq_side_type                      side4_ff;

   // numerators
   logic [S_W-1:0]               s5;
   logic signed [SUM_W-1:0]      b5, np5, nm5, a5x2;
   logic [SUM_W-1:0]             abs_p5, abs_m5, abs_d5;
   logic [NUM_W-1:0]             nump5_ff, numm5_ff;
   logic [DEN_W-1:0]             den5_ff;
   dv_side_type                  side5_ff, side5_in;

   // divider and side delay
   logic [NUM_W-1:0]             quo_p, quo_m;
   dv_side_type                  dvside_ff [DV_STEPS];
   dv_side_type                  dvo;
   logic signed [ROOT_W-1:0]     rp_o, rm_o, qp_ext, qm_ext;

   logic [KIND_W-1:0]            kind_ff;
   logic signed [DISC_W-1:0]     disc_ff;
   logic signed [ROOT_W-1:0]     rp_ff, rm_ff;

   assign adv       = !vld_ff[VLD_N-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[VLD_N-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // discriminant, then rounding to hundredths
   assign d2_in   = DISC_RAW_W'(bb1_ff) - (DISC_RAW_W'(ac1_ff) <<< 2);
   assign neg3    = d2_ff[DISC_RAW_W-1];
   assign mag3    = neg3 ? DISC_RAW_W'(-d2_ff) : DISC_RAW_W'(d2_ff);
   assign mag3w   = SCALE_W'(mag3);
   assign scaled3 = (mag3w << 6) + (mag3w << 5) + (mag3w << 2) + SCALE_W'(32768);
   assign kmag3   = scaled3[ROUND_SH +: DISC_W];

   always_comb begin
      priority if (a2_ff == '0)          kind3 = KIND_AZERO;
      else if (kmag3 == '0)              kind3 = KIND_ONE;
      else if (neg3)                     kind3 = KIND_NONE;
      else                               kind3 = KIND_TWO;
   end

   assign side3_in.kind = kind3;
   assign side3_in.k    = neg3 ? -$signed(kmag3) : $signed(kmag3);
   assign side3_in.a    = a2_ff;
   assign side3_in.b    = b2_ff;
   assign sqn3_in       = (kind3 == KIND_TWO) ? {kmag3, 16'd0} : '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         bb1_ff   <= req_coef_b * req_coef_b;
         ac1_ff   <= req_coef_a * req_coef_c;
         a1_ff    <= req_coef_a;
         b1_ff    <= req_coef_b;
         d2_ff    <= d2_in;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         side3_ff <= side3_in;
         sqn3_ff  <= sqn3_in;
      end
   end

   qrr_isqrt u_isqrt (
      .clock    (clock),
      .adv      (adv),
      .n_in     (sqn3_ff),
      .root_out (root_w)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sqside_ff[0] <= side3_ff;
         for (int i = 1; i < SQ_STEPS; i++) begin
            sqside_ff[i] <= sqside_ff[i-1];
         end
         prod4_ff <= root_w * DIV10_MUL;
         side4_ff <= sqside_ff[SQ_STEPS-1];
      end
   end

   // root numerators -b +/- s and divisor 2a, as magnitudes
   assign s5     = prod4_ff[DIV10_SH +: S_W];
   assign b5     = SUM_W'(side4_ff.b);
   assign np5    = $signed({1'b0, s5}) - b5;
   assign nm5    = -$signed({1'b0, s5}) - b5;
   assign a5x2   = SUM_W'(side4_ff.a) <<< 1;
   assign abs_p5 = np5[SUM_W-1] ? SUM_W'(-np5) : SUM_W'(np5);
   assign abs_m5 = nm5[SUM_W-1] ? SUM_W'(-nm5) : SUM_W'(nm5);
   assign abs_d5 = a5x2[SUM_W-1] ? SUM_W'(-a5x2) : SUM_W'(a5x2);

   assign side5_in.kind  = side4_ff.kind;
   assign side5_in.k     = side4_ff.k;
   assign side5_in.neg_p = np5[SUM_W-1] ^ side4_ff.a[COEF_W-1];
   assign side5_in.neg_m = nm5[SUM_W-1] ^ side4_ff.a[COEF_W-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         nump5_ff <= {abs_p5[S_W-1:0], 8'd0};
         numm5_ff <= {abs_m5[S_W-1:0], 8'd0};
         den5_ff  <= abs_d5[DEN_W-1:0];
         side5_ff <= side5_in;
      end
   end

   qrr_div u_div_p (
      .clock   (clock),
      .adv     (adv),
      .num_in  (nump5_ff),
      .den_in  (den5_ff),
      .quo_out (quo_p)
   );

   qrr_div u_div_m (
      .clock   (clock),
      .adv     (adv),
      .num_in  (numm5_ff),
      .den_in  (den5_ff),
      .quo_out (quo_m)
   );

   assign dvo    = dvside_ff[DV_STEPS-1];
   assign qp_ext = $signed(ROOT_W'(quo_p));
   assign qm_ext = $signed(ROOT_W'(quo_m));

   always_comb begin
      rp_o = '0;
      rm_o = '0;
      unique case (dvo.kind)
         KIND_TWO: begin
            rp_o = dvo.neg_p ? -qp_ext : qp_ext;
            rm_o = dvo.neg_m ? -qm_ext : qm_ext;
         end
         KIND_ONE: begin
            rp_o = dvo.neg_p ? -qp_ext : qp_ext;
         end
         KIND_NONE, KIND_AZERO: begin
            rp_o = '0;
         end
         default: begin
            rp_o = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dvside_ff[0] <= side5_ff;
         for (int i = 1; i < DV_STEPS; i++) begin
            dvside_ff[i] <= dvside_ff[i-1];
         end
         kind_ff <= dvo.kind;
         disc_ff <= dvo.k;
         rp_ff   <= rp_o;
         rm_ff   <= rm_o;
      end
   end

   assign rsp_valid           = vld_ff[VLD_N-1];
   assign rsp_root_kind       = kind_ff;
   assign rsp_disc_hundredths = disc_ff;
   assign rsp_root_plus       = rp_ff;
   assign rsp_root_minus      = rm_ff;

endmodule
`default_nettype wire
